// File: design/slstm_pkg.sv
// Shared constants, types and fixed-point helpers of the sequence similarity core.
package slstm_pkg;

  // Network dimensions.
  localparam int HIDDEN_SIZE  = 32;
  localparam int EMBED_SIZE   = 16;
  localparam int HEAD_SIZE    = 16;
  localparam int MAX_SAMPLES  = 512;
  localparam int WEIGHT_DEPTH = 8192;
  localparam int FEATURES     = 7;
  localparam int GATES        = 4 * HIDDEN_SIZE;
  localparam int COMB         = 3 * EMBED_SIZE;

  // Word offsets of the weight map.
  localparam int OFS_IH  = 0;
  localparam int OFS_HH  = OFS_IH + GATES * FEATURES;
  localparam int OFS_LB  = OFS_HH + GATES * HIDDEN_SIZE;
  localparam int OFS_PW  = OFS_LB + GATES;
  localparam int OFS_PB  = OFS_PW + EMBED_SIZE * HIDDEN_SIZE;
  localparam int OFS_F1W = OFS_PB + EMBED_SIZE;
  localparam int OFS_F1B = OFS_F1W + HEAD_SIZE * COMB;
  localparam int OFS_F2W = OFS_F1B + HEAD_SIZE;
  localparam int OFS_F2B = OFS_F2W + HEAD_SIZE;

  // Widths.
  localparam int WA_W  = $clog2(WEIGHT_DEPTH);
  localparam int ACC_W = 40;
  localparam int OC_W  = $clog2(GATES);
  localparam int TC_W  = $clog2(COMB + 2);
  localparam int HW    = $clog2(HIDDEN_SIZE);
  localparam int EW    = $clog2(EMBED_SIZE);
  localparam int SW    = $clog2(HEAD_SIZE);
  localparam int XI_W  = $clog2(FEATURES);
  localparam int CNT_W = 10;

  // 1.0 in Q4.12, used as the operand of every bias term.
  localparam logic signed [15:0] ONE_Q = 16'sd4096;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

  // Operation codes of the input channel.
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_SEQ1 = 2'd1;
  localparam logic [1:0] OP_SEQ2 = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_GATE, ST_ACT, ST_PROJ, ST_FC1, ST_FC2, ST_OUT
  } state_t;

  // One term handed to the multiply-accumulate pipeline.
  typedef struct packed {
    logic                    valid;
    logic [WA_W-1:0]         addr;
    logic signed [15:0]      opnd;
    logic                    first;
    logic                    last;
    logic [OC_W-1:0]         idx;
  } mac_issue_t;

  // One finished, rounded dot product.
  typedef struct packed {
    logic               valid;
    logic [OC_W-1:0]    idx;
    logic signed [15:0] value;
  } mac_result_t;

  // Sigmoid knots at the integers -8..8 in Q4.12.
  function automatic logic [11:0] sig_tab(input logic [4:0] k);
    logic [11:0] v;
    case (k)
      5'd0:    v = 12'd1;
      5'd1:    v = 12'd4;
      5'd2:    v = 12'd10;
      5'd3:    v = 12'd27;
      5'd4:    v = 12'd74;
      5'd5:    v = 12'd194;
      5'd6:    v = 12'd488;
      5'd7:    v = 12'd1102;
      5'd8:    v = 12'd2048;
      5'd9:    v = 12'd2994;
      5'd10:   v = 12'd3608;
      5'd11:   v = 12'd3902;
      5'd12:   v = 12'd4022;
      5'd13:   v = 12'd4069;
      5'd14:   v = 12'd4086;
      5'd15:   v = 12'd4092;
      default: v = 12'd4095;
    endcase
    return v;
  endfunction

  // Piecewise-linear sigmoid, interpolated step rounded half up.
  function automatic logic signed [15:0] sigm_q(input logic signed [15:0] x);
    logic [15:0] u;
    logic [11:0] lo;
    logic [11:0] hi;
    logic [11:0] d;
    logic [23:0] p;
    logic [24:0] ps;
    logic [12:0] r;
    u  = {~x[15], x[14:0]};
    lo = sig_tab({1'b0, u[15:12]});
    hi = sig_tab({1'b0, u[15:12]} + 5'd1);
    d  = hi - lo;
    p  = d * u[11:0];
    ps = {1'b0, p} + 25'd2048;
    r  = {1'b0, lo} + {1'b0, ps[23:12]};
    return $signed({3'b000, r});
  endfunction

  // tanh(x) = 2*sigmoid(sat(2x)) - 1.
  function automatic logic signed [15:0] tanh_q(input logic signed [15:0] x);
    logic signed [16:0] x2;
    logic signed [15:0] xs;
    logic signed [15:0] s;
    x2 = {x, 1'b0};
    if (x2 > 17'sd32767) begin
      xs = 16'sd32767;
    end else if (x2 < -17'sd32768) begin
      xs = -16'sd32768;
    end else begin
      xs = x2[15:0];
    end
    s = sigm_q(xs);
    return (s <<< 1) - ONE_Q;
  endfunction

  // Round a Q16.24 sum to Q4.12, halves up, and saturate.
  function automatic logic signed [15:0] rnd_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] t;
    logic signed [15:0]      r;
    t = (a + ACC_W'(2048)) >>> 12;
    if (t > SAT_HI) begin
      r = 16'sd32767;
    end else if (t < SAT_LO) begin
      r = -16'sd32768;
    end else begin
      r = t[15:0];
    end
    return r;
  endfunction

endpackage

// File: design/slstm_mac.sv
// Weight memory and the pipelined multiply-accumulate unit shared by all dot products.
module slstm_mac
  import slstm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [WA_W-1:0]    wr_addr,
  input  logic [15:0]        wr_data,
  input  mac_issue_t         iss,
  output mac_result_t        res,
  output logic               busy
);

  logic [15:0]         wmem [WEIGHT_DEPTH];
  logic signed [15:0]  rd_r;

  logic                s1_v_r;
  logic signed [15:0]  s1_opnd_r;
  logic                s1_first_r;
  logic                s1_last_r;
  logic [OC_W-1:0]     s1_idx_r;

  logic                s2_v_r;
  logic signed [31:0]  prod_r;
  logic                s2_first_r;
  logic                s2_last_r;
  logic [OC_W-1:0]     s2_idx_r;

  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic                    res_v_r;
  logic [OC_W-1:0]         res_idx_r;

  // Weight memory: loads from the input channel, one read per cycle for the terms.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      wmem[wr_addr] <= wr_data;
    end
    rd_r <= $signed(wmem[iss.addr]);
  end

  // Control flags of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      s1_v_r  <= iss.valid;
      s2_v_r  <= s1_v_r;
      res_v_r <= s2_v_r && s2_last_r;
    end
  end

  // Accumulate the new product, restarting on the first term of a sum.
  always_comb begin
    if (s2_first_r) begin
      acc_nxt = {{(ACC_W-32){prod_r[31]}}, prod_r};
    end else begin
      acc_nxt = acc_r + {{(ACC_W-32){prod_r[31]}}, prod_r};
    end
  end

  // Operand alignment, product and accumulator registers.
  always_ff @(posedge clk) begin
    s1_opnd_r  <= iss.opnd;
    s1_first_r <= iss.first;
    s1_last_r  <= iss.last;
    s1_idx_r   <= iss.idx;
    prod_r     <= rd_r * s1_opnd_r;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_idx_r   <= s1_idx_r;
    if (s2_v_r) begin
      acc_r <= acc_nxt;
    end
    res_idx_r <= s2_idx_r;
  end

  assign res.valid = res_v_r;
  assign res.idx   = res_idx_r;
  assign res.value = rnd_sat(acc_r);
  assign busy      = s1_v_r || s2_v_r || res_v_r;

endmodule

// File: design/siamese_lstm_similarity_core.sv
// Top level of the siamese LSTM sequence similarity core.
//
// The input channel carries three kinds of transaction: a weight word load
// (operation 0), a sample of the first sequence (1) or of the second (2).
// A load leaves the block idle. Each of the first 512 samples of a sequence
// runs one LSTM step: 128 gate dot products of 40 terms on the single
// multiply-accumulate unit, one term a cycle from the weight memory port,
// then, per hidden unit, the activations and the cell/hidden update.
// The marked last sample of a sequence adds the projection (16 x 33 terms);
// for the second sequence the FC1 (16 x 49) and FC2 (17) layers follow and
// one score transaction leaves on the output channel.
// in_stall is high while a sample is being processed.
// The score waits in an output register; if the receiver stalls, the block
// still takes new transactions and holds back only a following score.
// Reset clears hidden and cell state, the sample count and the output valid;
// the weight memory keeps no defined contents until loaded.
module siamese_lstm_similarity_core
  import slstm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [12:0]        in_weight_address,
  input  logic signed [15:0] in_weight_value,
  input  logic signed [15:0] in_feature_0,
  input  logic signed [15:0] in_feature_1,
  input  logic signed [15:0] in_feature_2,
  input  logic signed [15:0] in_feature_3,
  input  logic signed [15:0] in_feature_4,
  input  logic signed [15:0] in_feature_5,
  input  logic signed [15:0] in_feature_6,
  input  logic               in_last_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_similarity_score
);

  state_t state_r, state_nxt;

  logic [OC_W-1:0]  oc_r;
  logic [TC_W-1:0]  tc_r;
  logic             iss_done_r;
  logic [3:0]       step_r;
  logic [1:0]       op_r;
  logic             last_r;
  logic [CNT_W-1:0] count_r;

  logic signed [15:0] x_r   [FEATURES];
  logic signed [15:0] h_r   [HIDDEN_SIZE];
  logic signed [15:0] c_r   [HIDDEN_SIZE];
  logic signed [15:0] e1_r  [EMBED_SIZE];
  logic signed [15:0] e2_r  [EMBED_SIZE];
  logic signed [15:0] fc1_r [HEAD_SIZE];
  logic signed [15:0] z_r;

  logic signed [15:0] ig_r, fg_r, gg_r, og_r, cn_r, th_r;
  logic signed [31:0] p1_r, p2_r;

  logic signed [15:0] gs_mem [GATES];
  logic signed [15:0] gs_rd_r;
  logic [OC_W-1:0]    gs_ra;

  logic [15:0] out_r;
  logic        out_valid_r;

  logic            accept;
  logic            issuing;
  logic [TC_W-1:0] last_t;
  logic [OC_W-1:0] last_oc;
  logic            phase_done;
  logic [HW-1:0]   j;
  logic            j_last;
  logic [TC_W-1:0] tm1;
  logic [HW-1:0]   hk;
  logic [EW-1:0]   ek;
  logic [TC_W-1:0] ek_w;
  logic signed [16:0] dif;
  logic signed [16:0] adif;
  logic signed [15:0] comb_v;
  logic signed [15:0] c_new;

  mac_issue_t  iss;
  mac_result_t res;
  logic        mac_busy;

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state_r != ST_IDLE);
  assign j          = oc_r[HW-1:0];
  assign j_last     = (oc_r == OC_W'(HIDDEN_SIZE - 1));
  assign phase_done = iss_done_r && !mac_busy;
  assign tm1        = tc_r - TC_W'(1);

  slstm_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept && (in_operation == OP_LOAD)),
    .wr_addr (WA_W'(in_weight_address)),
    .wr_data (in_weight_value),
    .iss     (iss),
    .res     (res),
    .busy    (mac_busy)
  );

  // Last term and last output index of each dot-product phase.
  always_comb begin
    issuing = 1'b1;
    last_t  = TC_W'(FEATURES + HIDDEN_SIZE);
    last_oc = OC_W'(GATES - 1);
    case (state_r)
      ST_GATE: begin
        last_t  = TC_W'(FEATURES + HIDDEN_SIZE);
        last_oc = OC_W'(GATES - 1);
      end
      ST_PROJ: begin
        last_t  = TC_W'(HIDDEN_SIZE);
        last_oc = OC_W'(EMBED_SIZE - 1);
      end
      ST_FC1: begin
        last_t  = TC_W'(COMB);
        last_oc = OC_W'(HEAD_SIZE - 1);
      end
      ST_FC2: begin
        last_t  = TC_W'(HEAD_SIZE);
        last_oc = '0;
      end
      default: issuing = 1'b0;
    endcase
  end

  // Head input vector: first embedding, second embedding, absolute difference.
  always_comb begin
    if (tm1 < TC_W'(EMBED_SIZE)) begin
      ek_w = tm1;
    end else if (tm1 < TC_W'(2 * EMBED_SIZE)) begin
      ek_w = tm1 - TC_W'(EMBED_SIZE);
    end else begin
      ek_w = tm1 - TC_W'(2 * EMBED_SIZE);
    end
    ek   = ek_w[EW-1:0];
    dif  = {e1_r[ek][15], e1_r[ek]} - {e2_r[ek][15], e2_r[ek]};
    adif = dif[16] ? -dif : dif;
    if (tm1 < TC_W'(EMBED_SIZE)) begin
      comb_v = e1_r[ek];
    end else if (tm1 < TC_W'(2 * EMBED_SIZE)) begin
      comb_v = e2_r[ek];
    end else if (adif > 17'sd32767) begin
      comb_v = 16'sd32767;
    end else begin
      comb_v = adif[15:0];
    end
  end

  // Address and operand of the next term.
  always_comb begin
    logic [TC_W-1:0] hk_w;
    hk_w = (state_r == ST_GATE) ? tm1 - TC_W'(FEATURES) : tm1;
    hk   = hk_w[HW-1:0];
    iss.valid = issuing && !iss_done_r;
    iss.first = (tc_r == '0);
    iss.last  = (tc_r == last_t);
    iss.idx   = oc_r;
    iss.addr  = '0;
    iss.opnd  = ONE_Q;
    case (state_r)
      ST_GATE: begin
        if (tc_r == '0) begin
          iss.addr = WA_W'(OFS_LB) + WA_W'(oc_r);
        end else if (tc_r <= TC_W'(FEATURES)) begin
          iss.addr = WA_W'(OFS_IH) + WA_W'(oc_r) * WA_W'(FEATURES) + WA_W'(tm1);
          iss.opnd = x_r[tm1[XI_W-1:0]];
        end else begin
          iss.addr = WA_W'(OFS_HH) + WA_W'(oc_r) * WA_W'(HIDDEN_SIZE) + WA_W'(hk);
          iss.opnd = h_r[hk];
        end
      end
      ST_PROJ: begin
        if (tc_r == '0) begin
          iss.addr = WA_W'(OFS_PB) + WA_W'(oc_r);
        end else begin
          iss.addr = WA_W'(OFS_PW) + WA_W'(oc_r) * WA_W'(HIDDEN_SIZE) + WA_W'(hk);
          iss.opnd = h_r[hk];
        end
      end
      ST_FC1: begin
        if (tc_r == '0) begin
          iss.addr = WA_W'(OFS_F1B) + WA_W'(oc_r);
        end else begin
          iss.addr = WA_W'(OFS_F1W) + WA_W'(oc_r) * WA_W'(COMB) + WA_W'(tm1);
          iss.opnd = comb_v;
        end
      end
      ST_FC2: begin
        if (tc_r == '0) begin
          iss.addr = WA_W'(OFS_F2B);
        end else begin
          iss.addr = WA_W'(OFS_F2W) + WA_W'(tm1);
          iss.opnd = fc1_r[tm1[SW-1:0]];
        end
      end
      default: iss.valid = 1'b0;
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_operation == OP_SEQ1 || in_operation == OP_SEQ2)) begin
          if (count_r < CNT_W'(MAX_SAMPLES)) begin
            state_nxt = ST_GATE;
          end else if (in_last_sample) begin
            state_nxt = ST_PROJ;
          end
        end
      end
      ST_GATE: begin
        if (phase_done) state_nxt = ST_ACT;
      end
      ST_ACT: begin
        if (step_r == 4'd9 && j_last) state_nxt = last_r ? ST_PROJ : ST_IDLE;
      end
      ST_PROJ: begin
        if (phase_done) state_nxt = (op_r == OP_SEQ1) ? ST_IDLE : ST_FC1;
      end
      ST_FC1: begin
        if (phase_done) state_nxt = ST_FC2;
      end
      ST_FC2: begin
        if (phase_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register and loop counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      oc_r       <= '0;
      tc_r       <= '0;
      iss_done_r <= 1'b0;
      step_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r) begin
        oc_r       <= '0;
        tc_r       <= '0;
        iss_done_r <= 1'b0;
        step_r     <= '0;
      end else if (iss.valid) begin
        if (tc_r == last_t) begin
          tc_r <= '0;
          if (oc_r == last_oc) begin
            iss_done_r <= 1'b1;
          end else begin
            oc_r <= oc_r + OC_W'(1);
          end
        end else begin
          tc_r <= tc_r + TC_W'(1);
        end
      end else if (state_r == ST_ACT) begin
        if (step_r == 4'd9) begin
          step_r <= '0;
          oc_r   <= oc_r + OC_W'(1);
        end else begin
          step_r <= step_r + 4'd1;
        end
      end
    end
  end

  // Gate scratch memory: written by the gate phase, read back by the update.
  always_comb begin
    gs_ra = OC_W'(step_r[1:0]) * OC_W'(HIDDEN_SIZE) + OC_W'(j);
  end

  always_ff @(posedge clk) begin
    if (res.valid && state_r == ST_GATE) begin
      gs_mem[res.idx] <= res.value;
    end
    gs_rd_r <= gs_mem[gs_ra];
  end

  // New cell value from the two products of the update.
  assign c_new = rnd_sat({{(ACC_W-32){p1_r[31]}}, p1_r} + {{(ACC_W-32){p2_r[31]}}, p2_r});

  // Sequence state: hidden and cell vectors and the sample count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int k = 0; k < HIDDEN_SIZE; k++) begin
        h_r[k] <= '0;
        c_r[k] <= '0;
      end
    end else if (state_r == ST_PROJ && state_nxt != ST_PROJ) begin
      count_r <= '0;
      for (int k = 0; k < HIDDEN_SIZE; k++) begin
        h_r[k] <= '0;
        c_r[k] <= '0;
      end
    end else if (state_r == ST_ACT) begin
      if (step_r == 4'd6) begin
        c_r[j] <= c_new;
      end
      if (step_r == 4'd9) begin
        h_r[j] <= rnd_sat({{(ACC_W-32){p1_r[31]}}, p1_r});
        if (j_last) count_r <= count_r + CNT_W'(1);
      end
    end
  end

  // Sample capture and the activation and update steps of each hidden unit.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_operation;
      last_r <= in_last_sample;
      x_r[0] <= in_feature_0;
      x_r[1] <= in_feature_1;
      x_r[2] <= in_feature_2;
      x_r[3] <= in_feature_3;
      x_r[4] <= in_feature_4;
      x_r[5] <= in_feature_5;
      x_r[6] <= in_feature_6;
    end
    if (state_r == ST_ACT) begin
      case (step_r)
        4'd1: ig_r <= sigm_q(gs_rd_r);
        4'd2: fg_r <= sigm_q(gs_rd_r);
        4'd3: gg_r <= tanh_q(gs_rd_r);
        4'd4: begin
          og_r <= sigm_q(gs_rd_r);
          p1_r <= fg_r * c_r[j];
        end
        4'd5: p2_r <= ig_r * gg_r;
        4'd6: cn_r <= c_new;
        4'd7: th_r <= tanh_q(cn_r);
        4'd8: p1_r <= og_r * th_r;
        default: ;
      endcase
    end
  end

  // Results of the projection and head phases.
  always_ff @(posedge clk) begin
    if (res.valid) begin
      case (state_r)
        ST_PROJ: begin
          if (op_r == OP_SEQ1) begin
            e1_r[res.idx[EW-1:0]] <= res.value;
          end else begin
            e2_r[res.idx[EW-1:0]] <= res.value;
          end
        end
        ST_FC1:  fc1_r[res.idx[SW-1:0]] <= res.value[15] ? 16'sd0 : res.value;
        ST_FC2:  z_r <= res.value;
        default: ;
      endcase
    end
  end

  // Output register: the score in Q1.15.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && state_nxt == ST_IDLE) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && state_nxt == ST_IDLE) begin
      out_r <= 16'(sigm_q(z_r) <<< 3);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_similarity_score = out_r;

endmodule

// File: test/tb_siamese_lstm_similarity_core.sv
// Self-checking testbench of the siamese LSTM sequence similarity core.
module tb_siamese_lstm_similarity_core;
  import slstm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_WORDS = OFS_F2B + 1;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int WANT_ITEMS = 110;
  localparam int DRAIN_CYCLES = 8000;

  // Sigmoid knots at the integers -8..8 in Q4.12.
  localparam int SIG_KNOT [17] = '{1, 4, 10, 27, 74, 194, 488, 1102, 2048,
                                   2994, 3608, 3902, 4022, 4069, 4086, 4092, 4095};

  // One input transaction, with an optional hand-typed score.
  typedef struct {
    logic [1:0]         op;
    logic [12:0]        addr;
    logic signed [15:0] wval;
    logic signed [15:0] feat [FEATURES];
    logic               last;
    bit                 typed;
    logic [15:0]        typed_score;
  } sample_txn_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_operation = OP_NONE;
  logic [12:0]        in_weight_address = '0;
  logic signed [15:0] in_weight_value = '0;
  logic signed [15:0] in_feature_0 = '0;
  logic signed [15:0] in_feature_1 = '0;
  logic signed [15:0] in_feature_2 = '0;
  logic signed [15:0] in_feature_3 = '0;
  logic signed [15:0] in_feature_4 = '0;
  logic signed [15:0] in_feature_5 = '0;
  logic signed [15:0] in_feature_6 = '0;
  logic               in_last_sample = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [15:0]        out_similarity_score;

  siamese_lstm_similarity_core dut (.*);

  always #10 clk = ~clk;

  // Shadow copy of the network state.
  logic signed [15:0] shadow_weights [WEIGHT_DEPTH];
  int shadow_h [HIDDEN_SIZE];
  int shadow_c [HIDDEN_SIZE];
  int shadow_emb1 [EMBED_SIZE];
  int shadow_count;

  logic [15:0] pending_scores [$];
  sample_txn_t directed_rows [$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic int clamp16(int v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  // Round Q8.24 to Q4.12, halves up, then saturate.
  function automatic int round_q(longint acc);
    longint r;
    r = (acc + 2048) >>> 12;
    if (r > 32767) return 32767;
    if (r < -32768) return -32768;
    return int'(r);
  endfunction

  function automatic int sigmoid_q(int x);
    int u;
    int seg;
    int frac;
    u = clamp16(x) + 32768;
    seg = u / 4096;
    frac = u % 4096;
    return SIG_KNOT[seg] + ((SIG_KNOT[seg+1] - SIG_KNOT[seg]) * frac + 2048) / 4096;
  endfunction

  function automatic int tanh_pl(int x);
    return 2 * sigmoid_q(clamp16(2 * x)) - 4096;
  endfunction

  function automatic longint wt(int a);
    return longint'(shadow_weights[a % WEIGHT_DEPTH]);
  endfunction

  function automatic void advance_lstm(int x [FEATURES]);
    int gate [GATES];
    longint acc;
    int ig;
    int fg;
    int gg;
    int og;
    for (int g = 0; g < GATES; g++) begin
      acc = wt(OFS_LB + g) * 4096;
      for (int j = 0; j < FEATURES; j++) acc += wt(OFS_IH + g * FEATURES + j) * x[j];
      for (int j = 0; j < HIDDEN_SIZE; j++)
        acc += wt(OFS_HH + g * HIDDEN_SIZE + j) * shadow_h[j];
      gate[g] = round_q(acc);
    end
    for (int j = 0; j < HIDDEN_SIZE; j++) begin
      ig = sigmoid_q(gate[j]);
      fg = sigmoid_q(gate[HIDDEN_SIZE + j]);
      gg = tanh_pl(gate[2 * HIDDEN_SIZE + j]);
      og = sigmoid_q(gate[3 * HIDDEN_SIZE + j]);
      shadow_c[j] = round_q(longint'(fg) * shadow_c[j] + longint'(ig) * gg);
      shadow_h[j] = round_q(longint'(og) * tanh_pl(shadow_c[j]));
    end
  endfunction

  function automatic void embed_hidden(output int emb [EMBED_SIZE]);
    longint acc;
    for (int e = 0; e < EMBED_SIZE; e++) begin
      acc = wt(OFS_PB + e) * 4096;
      for (int k = 0; k < HIDDEN_SIZE; k++)
        acc += wt(OFS_PW + e * HIDDEN_SIZE + k) * shadow_h[k];
      emb[e] = round_q(acc);
    end
  endfunction

  function automatic int head_score(int e2 [EMBED_SIZE]);
    int comb [COMB];
    int fc1 [HEAD_SIZE];
    int d;
    longint acc;
    for (int i = 0; i < EMBED_SIZE; i++) begin
      d = shadow_emb1[i] - e2[i];
      comb[i] = shadow_emb1[i];
      comb[EMBED_SIZE + i] = e2[i];
      comb[2 * EMBED_SIZE + i] = clamp16(d < 0 ? -d : d);
    end
    for (int i = 0; i < HEAD_SIZE; i++) begin
      acc = wt(OFS_F1B + i) * 4096;
      for (int m = 0; m < COMB; m++) acc += wt(OFS_F1W + i * COMB + m) * comb[m];
      fc1[i] = round_q(acc) > 0 ? round_q(acc) : 0;
    end
    acc = wt(OFS_F2B) * 4096;
    for (int i = 0; i < HEAD_SIZE; i++) acc += wt(OFS_F2W + i) * fc1[i];
    return sigmoid_q(round_q(acc));
  endfunction

  function automatic void clear_sequence();
    foreach (shadow_h[j]) begin
      shadow_h[j] = 0;
      shadow_c[j] = 0;
    end
    shadow_count = 0;
  endfunction

  // Applies one accepted transaction; returns 1 with the score if one is due.
  function automatic bit predict_score(sample_txn_t t, output logic [15:0] score);
    int x [FEATURES];
    int emb [EMBED_SIZE];
    score = '0;
    if (t.op == OP_LOAD) begin
      shadow_weights[t.addr] = t.wval;
      return 1'b0;
    end
    if (t.op == OP_NONE) return 1'b0;
    foreach (x[j]) x[j] = t.feat[j];
    if (shadow_count < MAX_SAMPLES) begin
      advance_lstm(x);
      shadow_count++;
    end
    if (!t.last) return 1'b0;
    embed_hidden(emb);
    if (t.op == OP_SEQ1) begin
      shadow_emb1 = emb;
      clear_sequence();
      return 1'b0;
    end
    clear_sequence();
    score = 16'(head_score(emb) << 3);
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0d: %s got %0d, expected %0d", cycles, what, got, want);
    errors++;
  endtask

  // Drives one transaction, waits for acceptance and records its score.
  task automatic send_txn(sample_txn_t t);
    logic [15:0] score;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= t.op;
    in_weight_address <= t.addr;
    in_weight_value <= t.wval;
    in_feature_0 <= t.feat[0];
    in_feature_1 <= t.feat[1];
    in_feature_2 <= t.feat[2];
    in_feature_3 <= t.feat[3];
    in_feature_4 <= t.feat[4];
    in_feature_5 <= t.feat[5];
    in_feature_6 <= t.feat[6];
    in_last_sample <= t.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_score(t, score)) begin
      if (t.typed && score != t.typed_score)
        report_mismatch("typed score vs predictor", score, t.typed_score);
      pending_scores.push_back(t.typed ? t.typed_score : score);
    end
  endtask

  function automatic sample_txn_t make_txn(logic [1:0] op, int addr, int wval, int fv,
                                           logic last, bit typed, int want);
    sample_txn_t t;
    t.op = op;
    t.addr = 13'(addr);
    t.wval = 16'(wval);
    foreach (t.feat[j]) t.feat[j] = 16'(fv);
    t.last = last;
    t.typed = typed;
    t.typed_score = 16'(want);
    return t;
  endfunction

  function automatic logic signed [15:0] rand_word(int wide_pct);
    if ($urandom_range(99) < wide_pct) return 16'($urandom);
    return 16'($signed($urandom_range(2047)) - 1024);
  endfunction

  // Score check and receiver stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_scores.size() == 0) begin
        report_mismatch("unexpected score", out_similarity_score, 0);
      end else begin
        if (out_similarity_score != pending_scores[0])
          report_mismatch("similarity_score", out_similarity_score, pending_scores[0]);
        void'(pending_scores.pop_front());
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Run time limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    sample_txn_t t;
    int items;
    int seq_op;
    int seq_len;
    foreach (shadow_weights[a]) shadow_weights[a] = '0;
    foreach (shadow_emb1[e]) shadow_emb1[e] = 0;
    clear_sequence();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 18;
    recv_idle_pct = 78;

    // Clear the used part of the weight map so that scores are easy to read off.
    for (int a = 0; a < MAP_WORDS; a++) send_txn(make_txn(OP_LOAD, a, 0, 0, 1'b0, 0, 0));

    // Directed rows: with zero weights the score is sigmoid of the FC2 bias.
    directed_rows.push_back(make_txn(OP_NONE, 8191, -1, -1, 1'b1, 0, 0));
    directed_rows.push_back(make_txn(OP_SEQ1, 0, 0, 32767, 1'b1, 0, 0));
    directed_rows.push_back(make_txn(OP_SEQ2, 0, 0, -32768, 1'b1, 1, 16384));
    directed_rows.push_back(make_txn(OP_LOAD, OFS_F2B, 32767, 0, 1'b0, 0, 0));
    directed_rows.push_back(make_txn(OP_SEQ2, 0, 0, 0, 1'b1, 1, 32760));
    directed_rows.push_back(make_txn(OP_LOAD, OFS_F2B, -32768, 0, 1'b0, 0, 0));
    directed_rows.push_back(make_txn(OP_SEQ2, 0, 0, 12345, 1'b1, 1, 8));
    directed_rows.push_back(make_txn(OP_LOAD, 8191, -32768, 0, 1'b0, 0, 0));
    directed_rows.push_back(make_txn(OP_LOAD, 0, 32767, 0, 1'b0, 0, 0));
    directed_rows.push_back(make_txn(OP_LOAD, OFS_LB + 2 * HIDDEN_SIZE, 4096, 0, 1'b0, 0, 0));
    directed_rows.push_back(make_txn(OP_LOAD, OFS_LB + 3 * HIDDEN_SIZE, 8192, 0, 1'b0, 0, 0));
    directed_rows.push_back(make_txn(OP_LOAD, OFS_PW, 4096, 0, 1'b0, 0, 0));
    directed_rows.push_back(make_txn(OP_LOAD, OFS_F1W + 2 * EMBED_SIZE, 4096, 0, 1'b0, 0, 0));
    directed_rows.push_back(make_txn(OP_LOAD, OFS_F2W, 4096, 0, 1'b0, 0, 0));
    directed_rows.push_back(make_txn(OP_LOAD, OFS_F2B, 0, 0, 1'b0, 0, 0));
    // A sequence that starts as the second and is finished as the first.
    directed_rows.push_back(make_txn(OP_SEQ2, 0, 0, 32767, 1'b0, 0, 0));
    directed_rows.push_back(make_txn(OP_SEQ1, 0, 0, -1, 1'b1, 0, 0));
    // And one the other way round, which produces a score.
    directed_rows.push_back(make_txn(OP_SEQ1, 0, 0, 4096, 1'b0, 0, 0));
    directed_rows.push_back(make_txn(OP_NONE, 0, 0, 0, 1'b0, 0, 0));
    directed_rows.push_back(make_txn(OP_SEQ2, 0, 0, -4096, 1'b1, 0, 0));
    foreach (directed_rows[i]) send_txn(directed_rows[i]);

    // Fill the map with small random weights, a few of them full range.
    for (int a = 0; a < MAP_WORDS; a++)
      send_txn(make_txn(OP_LOAD, a, rand_word(3), 0, 1'b0, 0, 0));

    // Random part: short sequences with random content, loads and some noise.
    items = 0;
    seq_len = 0;
    seq_op = OP_SEQ2;
    while (items < WANT_ITEMS) begin
      if (items == WANT_ITEMS / 3) begin
        send_idle_pct = 78;
        recv_idle_pct = 18;
      end else if (items == 2 * WANT_ITEMS / 3) begin
        // Hold the sender back until the block has nothing outstanding.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_scores.size() != 0) @(posedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      t = make_txn(OP_LOAD, 0, 0, 0, 1'b0, 0, 0);
      case ($urandom_range(19))
        0, 1, 2, 3, 4: begin
          t.op = OP_LOAD;
          t.addr = 13'($urandom);
          t.wval = rand_word(20);
        end
        5: begin
          t.op = OP_NONE;
          t.addr = 13'($urandom);
          t.wval = 16'($urandom);
          foreach (t.feat[j]) t.feat[j] = 16'($urandom);
          t.last = 1'($urandom);
        end
        default: begin
          if (seq_len == 0) seq_op = ($urandom_range(9) < 7) ? OP_SEQ2 : OP_SEQ1;
          // Now and then the operation changes within a sequence.
          t.op = ($urandom_range(9) == 0) ? 2'(OP_SEQ1 + OP_SEQ2 - seq_op) : 2'(seq_op);
          t.addr = 13'($urandom);
          t.wval = 16'($urandom);
          foreach (t.feat[j]) t.feat[j] = ($urandom_range(1) == 0) ? 16'($urandom) :
                                          16'($signed($urandom_range(8191)) - 4096);
          t.last = (seq_len >= 2) || ($urandom_range(1) == 0);
          seq_len = t.last ? 0 : seq_len + 1;
        end
      endcase
      send_txn(t);
      items++;
    end
    in_valid <= 1'b0;

    // Drain outstanding scores, then give the block time to go quiet.
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
design/slstm_pkg.sv
design/slstm_mac.sv
design/siamese_lstm_similarity_core.sv
test/tb_siamese_lstm_similarity_core.sv
